### rtl/core/rsf_pkg.sv
package rsf_pkg;

  localparam int NUM_CORNERS = 4;
  localparam int NUM_EDGES   = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIR_A_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_A_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_B_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_B_Y = 2'd3;

  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_TOP    = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_t;

  typedef struct packed {
    logic valid;
    logic set_end;
  } rsf_ctl_t;

endpackage

### rtl/core/rotated_edge_square_finder.sv
// A set_end word passes ctl1, ctl2 and ctl; its update then sets out_valid (busy).
// One result word per ready cycle, four per set, in order left, top, right, bottom.
// Throughput: one input word per cycle, but the best-square update stage holds
// while a set's results go out, and in_ready drops once a valid word waits in ctl.
// Reset (synchronous): empties the pipeline and the set, and returns both directions
// to the unit axes.
module rotated_edge_square_finder
  import rsf_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [FRAC_BITS+1:0]                   cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [COORD_BITS-1:0]                  corner0_x,
  input  logic [COORD_BITS-1:0]                  corner0_y,
  input  logic [COORD_BITS-1:0]                  corner1_x,
  input  logic [COORD_BITS-1:0]                  corner1_y,
  input  logic [COORD_BITS-1:0]                  corner2_x,
  input  logic [COORD_BITS-1:0]                  corner2_y,
  input  logic [COORD_BITS-1:0]                  corner3_x,
  input  logic [COORD_BITS-1:0]                  corner3_y,
  input  logic                                   set_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             edge_code,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] proj0_a,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] proj0_b,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] proj1_a,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] proj1_b,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] proj2_a,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] proj2_b,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] proj3_a,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] proj3_b,
  output logic                                   final_edge
);

  localparam int DIR_W  = FRAC_BITS + 2;
  localparam int PROJ_W = COORD_BITS + FRAC_BITS + 3;
  localparam logic signed [DIR_W-1:0] DIR_ONE = {2'b01, {FRAC_BITS{1'b0}}};

  logic signed [DIR_W-1:0]  dir_a_x, dir_a_y, dir_b_x, dir_b_y;
  logic [COORD_BITS-1:0]    cx [NUM_CORNERS];
  logic [COORD_BITS-1:0]    cy [NUM_CORNERS];
  logic signed [PROJ_W-1:0] pa [NUM_CORNERS];
  logic signed [PROJ_W-1:0] pb [NUM_CORNERS];
  logic signed [PROJ_W-1:0] out_a [NUM_CORNERS];
  logic signed [PROJ_W-1:0] out_b [NUM_CORNERS];
  rsf_ctl_t                 ctl1, ctl2;
  logic                     adv;
  edge_t                    code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_a_x <= DIR_ONE;
      dir_a_y <= '0;
      dir_b_x <= '0;
      dir_b_y <= DIR_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIR_A_X: dir_a_x <= signed'(cfg_data);
        CFG_DIR_A_Y: dir_a_y <= signed'(cfg_data);
        CFG_DIR_B_X: dir_b_x <= signed'(cfg_data);
        CFG_DIR_B_Y: dir_b_y <= signed'(cfg_data);
      endcase
    end
  end

  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
    end else if (adv) begin
      ctl1 <= '{valid: in_valid, set_end: set_end};
      ctl2 <= ctl1;
    end
  end

  assign cx[0] = corner0_x;
  assign cy[0] = corner0_y;
  assign cx[1] = corner1_x;
  assign cy[1] = corner1_y;
  assign cx[2] = corner2_x;
  assign cy[2] = corner2_y;
  assign cx[3] = corner3_x;
  assign cy[3] = corner3_y;

  for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_lane
    rsf_lane #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (adv),
      .x      (cx[c]),
      .y      (cy[c]),
      .dir_ax (dir_a_x),
      .dir_ay (dir_a_y),
      .dir_bx (dir_b_x),
      .dir_by (dir_b_y),
      .pa     (pa[c]),
      .pb     (pb[c])
    );
  end

  rsf_merge #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (ctl2),
    .pa         (pa),
    .pb         (pb),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_code  (code),
    .out_a      (out_a),
    .out_b      (out_b),
    .final_edge (final_edge)
  );

  assign edge_code = code;
  assign proj0_a   = out_a[0];
  assign proj0_b   = out_b[0];
  assign proj1_a   = out_a[1];
  assign proj1_b   = out_b[1];
  assign proj2_a   = out_a[2];
  assign proj2_b   = out_b[2];
  assign proj3_a   = out_a[3];
  assign proj3_b   = out_b[3];

endmodule

### rtl/core/rsf_lane.sv
module rsf_lane
  import rsf_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [COORD_BITS-1:0]                    x,
  input  logic [COORD_BITS-1:0]                    y,
  input  logic signed [FRAC_BITS+1:0]              dir_ax,
  input  logic signed [FRAC_BITS+1:0]              dir_ay,
  input  logic signed [FRAC_BITS+1:0]              dir_bx,
  input  logic signed [FRAC_BITS+1:0]              dir_by,
  output logic signed [COORD_BITS+FRAC_BITS+2:0]   pa,
  output logic signed [COORD_BITS+FRAC_BITS+2:0]   pb
);

  localparam int DIR_W  = FRAC_BITS + 2;
  localparam int PROD_W = DIR_W + COORD_BITS;
  localparam int PROJ_W = PROD_W + 1;

  logic signed [COORD_BITS:0] xs;
  logic signed [COORD_BITS:0] ys;
  logic signed [PROD_W-1:0]   mul_ax;
  logic signed [PROD_W-1:0]   mul_ay;
  logic signed [PROD_W-1:0]   mul_bx;
  logic signed [PROD_W-1:0]   mul_by;
  logic signed [PROD_W-1:0]   prod_ax;
  logic signed [PROD_W-1:0]   prod_ay;
  logic signed [PROD_W-1:0]   prod_bx;
  logic signed [PROD_W-1:0]   prod_by;

  assign xs = signed'({1'b0, x});
  assign ys = signed'({1'b0, y});

  assign mul_ax = PROD_W'(dir_ax) * PROD_W'(xs);
  assign mul_ay = PROD_W'(dir_ay) * PROD_W'(ys);
  assign mul_bx = PROD_W'(dir_bx) * PROD_W'(xs);
  assign mul_by = PROD_W'(dir_by) * PROD_W'(ys);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ax <= mul_ax;
      prod_ay <= mul_ay;
      prod_bx <= mul_bx;
      prod_by <= mul_by;
      pa      <= PROJ_W'(prod_ax) + PROJ_W'(prod_ay);
      pb      <= PROJ_W'(prod_bx) + PROJ_W'(prod_by);
    end
  end

endmodule

### rtl/core/rsf_merge.sv
module rsf_merge
  import rsf_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rsf_ctl_t                               ctl_in,
  input  logic signed [COORD_BITS+FRAC_BITS+2:0] pa [NUM_CORNERS],
  input  logic signed [COORD_BITS+FRAC_BITS+2:0] pb [NUM_CORNERS],
  output logic                                   adv,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output edge_t                                  edge_code,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] out_a [NUM_CORNERS],
  output logic signed [COORD_BITS+FRAC_BITS+2:0] out_b [NUM_CORNERS],
  output logic                                   final_edge
);

  localparam int PROJ_W = COORD_BITS + FRAC_BITS + 3;

  rsf_ctl_t                  ctl;
  logic signed [PROJ_W-1:0]  min_a01, min_a23, max_a01, max_a23;
  logic signed [PROJ_W-1:0]  min_b01, min_b23, max_b01, max_b23;
  logic signed [PROJ_W-1:0]  score [NUM_EDGES];
  logic signed [PROJ_W-1:0]  q_a [NUM_CORNERS];
  logic signed [PROJ_W-1:0]  q_b [NUM_CORNERS];
  logic signed [PROJ_W-1:0]  best_score [NUM_EDGES];
  logic signed [PROJ_W-1:0]  best_a [NUM_EDGES][NUM_CORNERS];
  logic signed [PROJ_W-1:0]  best_b [NUM_EDGES][NUM_CORNERS];
  logic                      holds_square;
  logic                      busy;
  edge_t                     cnt;
  logic                      upd;
  logic [NUM_EDGES-1:0]      take;

  // Per-edge extremes over the four corners, as a two-level tree.
  assign min_a01 = (pa[1] < pa[0]) ? pa[1] : pa[0];
  assign min_a23 = (pa[3] < pa[2]) ? pa[3] : pa[2];
  assign max_a01 = (pa[1] > pa[0]) ? pa[1] : pa[0];
  assign max_a23 = (pa[3] > pa[2]) ? pa[3] : pa[2];
  assign min_b01 = (pb[1] < pb[0]) ? pb[1] : pb[0];
  assign min_b23 = (pb[3] < pb[2]) ? pb[3] : pb[2];
  assign max_b01 = (pb[1] > pb[0]) ? pb[1] : pb[0];
  assign max_b23 = (pb[3] > pb[2]) ? pb[3] : pb[2];

  assign adv = !(ctl.valid && busy);
  assign upd = ctl.valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= ctl_in;
    end
  end

  // Left and bottom scores are kept as minima of a and b, so a better
  // square there has a strictly smaller value.
  always_ff @(posedge clk) begin
    if (adv) begin
      score[EDGE_LEFT]   <= (min_a23 < min_a01) ? min_a23 : min_a01;
      score[EDGE_TOP]    <= (max_b23 > max_b01) ? max_b23 : max_b01;
      score[EDGE_RIGHT]  <= (max_a23 > max_a01) ? max_a23 : max_a01;
      score[EDGE_BOTTOM] <= (min_b23 < min_b01) ? min_b23 : min_b01;
      q_a <= pa;
      q_b <= pb;
    end
  end

  always_comb begin
    take[EDGE_LEFT]   = !holds_square || (score[EDGE_LEFT] < best_score[EDGE_LEFT]);
    take[EDGE_TOP]    = !holds_square || (score[EDGE_TOP] > best_score[EDGE_TOP]);
    take[EDGE_RIGHT]  = !holds_square || (score[EDGE_RIGHT] > best_score[EDGE_RIGHT]);
    take[EDGE_BOTTOM] = !holds_square || (score[EDGE_BOTTOM] < best_score[EDGE_BOTTOM]);
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      for (int e = 0; e < NUM_EDGES; e++) begin
        if (take[e]) begin
          best_score[e] <= score[e];
          best_a[e]     <= q_a;
          best_b[e]     <= q_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holds_square <= 1'b0;
      busy         <= 1'b0;
      cnt          <= EDGE_LEFT;
    end else if (upd) begin
      holds_square <= !ctl.set_end;
      busy         <= ctl.set_end;
      cnt          <= EDGE_LEFT;
    end else if (busy && out_ready) begin
      if (cnt == EDGE_BOTTOM) begin
        busy <= 1'b0;
      end else begin
        cnt <= edge_t'(cnt + 2'd1);
      end
    end
  end

  assign out_valid  = busy;
  assign edge_code  = cnt;
  assign final_edge = (cnt == EDGE_BOTTOM);

  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      out_a[c] = best_a[cnt][c];
      out_b[c] = best_b[cnt][c];
    end
  end

endmodule

### rtl/core/rsf_checker.sv
module rsf_checker
  import rsf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] edge_code,
  input logic       final_edge
);

  // A stalled result word holds its edge.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_code))
    else $error("result word changed while stalled");

  // A burst of results always opens with the left edge.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> edge_code == EDGE_LEFT)
    else $error("result burst did not start with the left edge");

  // Once a word goes, the next edge follows at once until the bottom one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && edge_code != EDGE_BOTTOM |=>
      out_valid && edge_code == $past(edge_code) + 2'd1)
    else $error("result burst broke before the bottom edge");

  // The final mark belongs to the bottom edge only.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> final_edge == (edge_code == EDGE_BOTTOM))
    else $error("final mark on the wrong edge");

endmodule

bind rotated_edge_square_finder rsf_checker u_rsf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .edge_code  (edge_code),
  .final_edge (final_edge)
);
